// File: rtl/multi_delimiter_splitter_core_defines.svh
// Assertion macros used by the splitter datapath.
`ifndef MULTI_DELIMITER_SPLITTER_CORE_DEFINES_SVH
`define MULTI_DELIMITER_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MDS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MDS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mds_pkg.sv
// Types, register indexes and helpers shared by the splitter modules.
package mds_pkg;

   // Delimiter register slots and field widths
   localparam int NumWords  = 4;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 64;
   localparam int LenFieldW = 4;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] REG_WORD_A  = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_WORD_B  = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_WORD_C  = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_WORD_D  = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_LENGTHS = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_FOLD    = 3'd5;

   // Result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FLUSH,
      ST_CLOSE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic append;    // write the accepted byte into the window
      logic decide;    // one decision at the window head, result to output
      logic close;     // end-of-text marker to output
      logic run_last;  // result is the last one for its input beat
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;     // output register can take a result this cycle
      logic full_next;    // window fills with the next appended byte
      logic drain_empty;  // window empty after the current decision
   } dp_stat_type;

   // ASCII lower-case folding
   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
      logic [7:0] r;
      r = b;
      if (en && b >= 8'h41 && b <= 8'h5a) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

// File: rtl/mds_ctrl.sv
// Splitter controller: sequences accept, decisions, flush and close.
module mds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_text_last,
   output logic                 req_ready,
   input  mds_pkg::dp_stat_type stat,
   output mds_pkg::ctrl_cmd_type cmd
);
   import mds_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_text_last) begin
                  state_in = ST_FLUSH;
               end else if (stat.full_next) begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (stat.out_free && stat.drain_empty) state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.append = req_valid;
         end
         ST_STEP: begin
            cmd.decide   = stat.out_free;
            cmd.run_last = 1'b1;
         end
         ST_FLUSH: begin
            cmd.decide = stat.out_free;
         end
         ST_CLOSE: begin
            cmd.close    = stat.out_free;
            cmd.run_last = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/mds_dpath.sv
// Splitter datapath: config registers, lookahead window, matcher, output register.
`include "multi_delimiter_splitter_core_defines.svh"

module mds_dpath #(
   parameter int MAX_DELIM_LEN = 8,
   parameter int NUM_DELIMS    = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mds_pkg::ctrl_cmd_type          cmd,
   output mds_pkg::dp_stat_type           stat,
   input  logic [7:0]                     req_text_byte,
   input  logic                           csr_valid,
   input  logic [mds_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [mds_pkg::CsrDataW-1:0]   csr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_item_kind,
   output logic [7:0]                     rsp_data_byte,
   output logic                           rsp_text_done,
   output logic                           rsp_run_last
);
   import mds_pkg::*;

   localparam int CntW       = $clog2(MAX_DELIM_LEN + 1);
   localparam int UsedDelims = (NUM_DELIMS < NumWords) ? NUM_DELIMS : NumWords;
   localparam logic [LenFieldW-1:0] MaxLen = LenFieldW'(MAX_DELIM_LEN);
   localparam logic [CntW-1:0] CntFullM1 = CntW'(MAX_DELIM_LEN - 1);

   // Configuration
   logic [CsrDataW-1:0]    word_ff [NumWords];
   logic [4*LenFieldW-1:0] lens_ff;
   logic                   fold_ff;

   // Window
   logic [7:0]      win_ff [MAX_DELIM_LEN];
   logic [7:0]      win_in [MAX_DELIM_LEN];
   logic [CntW-1:0] cnt_ff, cnt_in;

   // Matcher
   logic [LenFieldW-1:0] cand_len [UsedDelims];
   logic [LenFieldW-1:0] best_len;
   logic [LenFieldW-1:0] drop_len;
   logic [LenFieldW-1:0] cnt_ext;

   // Output register
   logic       out_valid_ff;
   logic       out_kind_ff;
   logic [7:0] out_byte_ff;
   logic       out_done_ff;
   logic       out_last_ff;
   logic       out_load;

   // Config writes; indexes past the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NumWords; w++) word_ff[w] <= '0;
         lens_ff <= '0;
         fold_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WORD_A:  word_ff[0] <= csr_data;
            REG_WORD_B:  word_ff[1] <= csr_data;
            REG_WORD_C:  word_ff[2] <= csr_data;
            REG_WORD_D:  word_ff[3] <= csr_data;
            REG_LENGTHS: lens_ff    <= csr_data[4*LenFieldW-1:0];
            REG_FOLD:    fold_ff    <= csr_data[0];
            default:     fold_ff    <= fold_ff;
         endcase
      end
   end

   assign cnt_ext = LenFieldW'(cnt_ff);

   // Per-delimiter compare at the window head
   always_comb begin
      for (int d = 0; d < UsedDelims; d++) begin
         logic [LenFieldW-1:0] len;
         logic                 hit;
         len = lens_ff[d*LenFieldW +: LenFieldW];
         hit = (len != '0) && (len <= MaxLen) && (len <= cnt_ext);
         for (int k = 0; k < MAX_DELIM_LEN; k++) begin
            if (LenFieldW'(k) < len &&
                fold_byte(win_ff[k], fold_ff) != fold_byte(word_ff[d][8*k +: 8], fold_ff)) begin
               hit = 1'b0;
            end
         end
         cand_len[d] = hit ? len : '0;
      end
   end

   // Longest match
   always_comb begin
      best_len = '0;
      for (int d = 0; d < UsedDelims; d++) begin
         if (cand_len[d] > best_len) best_len = cand_len[d];
      end
   end

   assign drop_len = (best_len != '0) ? best_len : LenFieldW'(1);

   // Window shift by the dropped byte count
   always_comb begin
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
         win_in[i] = win_ff[i];
         for (int n = 1; n < MAX_DELIM_LEN - i; n++) begin
            if (drop_len == LenFieldW'(n)) win_in[i] = win_ff[i + n];
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.decide) begin
         cnt_in = cnt_ff - CntW'(drop_len);
      end else if (cmd.append) begin
         cnt_in = cnt_ff + CntW'(1);
      end
   end

   // Window storage
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         for (int i = 0; i < MAX_DELIM_LEN; i++) win_ff[i] <= win_in[i];
      end else if (cmd.append) begin
         for (int i = 0; i < MAX_DELIM_LEN; i++) begin
            if (cnt_ff == CntW'(i)) win_ff[i] <= req_text_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Output register
   assign out_load = cmd.decide || cmd.close;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.close) begin
         out_kind_ff <= KIND_END;
         out_byte_ff <= 8'h00;
         out_done_ff <= 1'b1;
         out_last_ff <= cmd.run_last;
      end else if (cmd.decide) begin
         out_kind_ff <= (best_len != '0) ? KIND_END : KIND_DATA;
         out_byte_ff <= (best_len != '0) ? 8'h00 : win_ff[0];
         out_done_ff <= 1'b0;
         out_last_ff <= cmd.run_last;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_item_kind = out_kind_ff;
   assign rsp_data_byte = out_byte_ff;
   assign rsp_text_done = out_done_ff;
   assign rsp_run_last  = out_last_ff;

   // Status to the controller
   assign stat.out_free    = !out_valid_ff || rsp_ready;
   assign stat.full_next   = (cnt_ff == CntFullM1);
   assign stat.drain_empty = (cnt_in == '0);

   // Checks
   `MDS_ASSERT_IMP(a_append_room, clock, reset, cmd.append,
      cnt_ff < CntW'(MAX_DELIM_LEN), "byte appended to a full window")
   `MDS_ASSERT_IMP(a_decide_nonempty, clock, reset, cmd.decide,
      cnt_ff != '0, "decision on an empty window")
   `MDS_ASSERT_IMP(a_load_free, clock, reset, out_load,
      !out_valid_ff || rsp_ready, "result overwrote a pending beat")
   `MDS_ASSERT_IMP(a_close_empty, clock, reset, cmd.close,
      cnt_ff == '0, "text closed with bytes left in the window")
   `MDS_ASSERT_NXT(a_load_valid, clock, reset, out_load,
      out_valid_ff, "loaded result not presented")

endmodule

// File: rtl/multi_delimiter_splitter_core.sv
// Top level of the multi-delimiter text splitter.
// Usage:
//   req_* takes one text byte per beat with req_text_last on the final byte.
//   rsp_* gives result beats: data bytes of the current token, end-of-token
//   markers (one per matched delimiter), and a closing end-of-token with
//   rsp_text_done after the final byte. rsp_run_last flags the last result
//   caused by an input beat.
//   csr_* writes the delimiter words, lengths and fold flag; csr_ready is
//   always high and writes are meant for an idle block.
// Sequencing:
//   A byte that does not fill the lookahead window is taken while idle and
//   gives no result. A byte that fills it is accepted, then one decision at
//   the window head follows once the output is free; its result is
//   registered and visible the cycle after. The final byte is accepted, then
//   flush decisions empty the window, then the close marker follows; each
//   flush decision and the close marker use one output-register load.
// Reset clears the window count, the config registers and the output valid.
// While rsp_ready is low the controller holds its next result and stops
// accepting bytes once a decision is pending.
module multi_delimiter_splitter_core #(
   parameter int MAX_DELIM_LEN = 8,
   parameter int NUM_DELIMS    = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_text_byte,
   input  logic                          req_text_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_item_kind,
   output logic [7:0]                    rsp_data_byte,
   output logic                          rsp_text_done,
   output logic                          rsp_run_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mds_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [mds_pkg::CsrDataW-1:0]  csr_data
);
   import mds_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign csr_ready = 1'b1;

   // Controller
   mds_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_text_last (req_text_last),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // Datapath
   mds_dpath #(
      .MAX_DELIM_LEN (MAX_DELIM_LEN),
      .NUM_DELIMS    (NUM_DELIMS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_text_byte (req_text_byte),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item_kind (rsp_item_kind),
      .rsp_data_byte (rsp_data_byte),
      .rsp_text_done (rsp_text_done),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

// File: tb/tb_multi_delimiter_splitter_core.sv
// Self-checking bench for the multi-delimiter splitter core: directed table, then random texts.
module tb_multi_delimiter_splitter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mds_pkg::*;

   localparam int WIN_DEPTH     = 8;
   localparam int SLOT_COUNT    = 4;
   localparam int RANDOM_BYTES  = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 16;
   localparam int MAX_PRINTS    = 40;

   // Indexes past the register map
   localparam logic [CsrIdxW-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_SPARE_HI = 3'd7;

   localparam logic [CsrIdxW-1:0] WORD_REGS [SLOT_COUNT] =
      '{REG_WORD_A, REG_WORD_B, REG_WORD_C, REG_WORD_D};
   localparam logic [7:0] SEP_BYTES [6] = '{",", ";", " ", "|", "-", 8'h09};

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       text_done;
      logic       run_last;
   } token_beat_type;

   localparam token_beat_type END_OF_TEXT = '{KIND_END, 8'h00, 1'b1, 1'b1};

   typedef enum logic {ROW_BYTE, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type          op;
      logic [CsrIdxW-1:0]  idx;
      logic [CsrDataW-1:0] data;
      logic [7:0]          text_byte;
      logic                last;
      logic                pinned;
      token_beat_type      want;
   } plan_row_type;

   typedef enum logic [1:0] {RDY_OPEN, RDY_COIN, RDY_MASK, RDY_CHOKE} rdy_mode_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [7:0]          req_text_byte = 8'h00;
   logic                req_text_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic                rsp_item_kind;
   logic [7:0]          rsp_data_byte;
   logic                rsp_text_done;
   logic                rsp_run_last;
   logic                csr_valid     = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index     = '0;
   logic [CsrDataW-1:0] csr_data      = '0;

   // Splitter shadow: window and register copies
   logic [7:0]          win_bytes [WIN_DEPTH];
   int unsigned         win_fill  = 0;
   logic [63:0]         cfg_words [SLOT_COUNT] = '{64'h0, 64'h0, 64'h0, 64'h0};
   logic [15:0]         cfg_lens  = 16'h0000;
   logic                cfg_fold  = 1'b0;
   token_beat_type      pending_beats [$];

   int unsigned         fail_count    = 0;
   int unsigned         beats_checked = 0;
   int unsigned         sent_bytes    = 0;
   int unsigned         texts_done    = 0;
   int unsigned         csr_writes    = 0;
   int unsigned         drain_pauses  = 0;
   int unsigned         burst_left    = 0;

   rdy_mode_type        ready_mode    = RDY_OPEN;
   int unsigned         ready_left    = 0;
   logic [7:0]          ready_mask    = 8'h01;

   multi_delimiter_splitter_core #(
      .MAX_DELIM_LEN(WIN_DEPTH),
      .NUM_DELIMS   (SLOT_COUNT)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_text_byte(req_text_byte),
      .req_text_last(req_text_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_item_kind(rsp_item_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_text_done(rsp_text_done),
      .rsp_run_last (rsp_run_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shadow model

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      if (cfg_fold && c >= 8'h41 && c <= 8'h5a) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // Longest live delimiter matching at the window head, 0 if none
   function automatic int unsigned longest_delim();
      int unsigned best;
      int unsigned len;
      logic        hit;
      best = 0;
      for (int d = 0; d < SLOT_COUNT; d++) begin
         len = 32'(cfg_lens[4*d +: 4]);
         hit = (len != 0) && (len <= WIN_DEPTH) && (len <= win_fill);
         for (int k = 0; k < WIN_DEPTH; k++) begin
            if (hit && k < len) begin
               if (fold_lower(win_bytes[k]) != fold_lower(cfg_words[d][8*k +: 8])) begin
                  hit = 1'b0;
               end
            end
         end
         if (hit && len > best) begin
            best = len;
         end
      end
      return best;
   endfunction

   // One decision at the head: a match drops the delimiter, else the head byte is data
   function automatic token_beat_type decide_head();
      token_beat_type beat;
      int unsigned    span;
      span = longest_delim();
      if (span > 0) begin
         beat = '{KIND_END, 8'h00, 1'b0, 1'b0};
      end else begin
         beat = '{KIND_DATA, win_bytes[0], 1'b0, 1'b0};
         span = 1;
      end
      if (span >= win_fill) begin
         win_fill = 0;
      end else begin
         for (int i = 0; i + span < win_fill; i++) begin
            win_bytes[i] = win_bytes[i + span];
         end
         win_fill -= span;
      end
      return beat;
   endfunction

   // Expected beats for one accepted text byte; a pinned row types in its final beat
   function automatic void predict_byte(input logic [7:0] b, input logic last,
                                        input logic pinned, input token_beat_type want);
      token_beat_type beats [$];
      if (win_fill < WIN_DEPTH) begin
         win_bytes[win_fill] = b;
         win_fill++;
      end
      if (!last) begin
         if (win_fill >= WIN_DEPTH) begin
            beats = {beats, decide_head()};
         end
      end else begin
         while (win_fill > 0) begin
            beats = {beats, decide_head()};
         end
         beats = {beats, END_OF_TEXT};
      end
      if (beats.size() > 0) begin
         beats[beats.size() - 1].run_last = 1'b1;
         if (pinned) begin
            beats[beats.size() - 1] = want;
         end
      end
      foreach (beats[i]) begin
         pending_beats = {pending_beats, beats[i]};
      end
   endfunction

   function automatic void apply_config(input logic [CsrIdxW-1:0] idx,
                                        input logic [CsrDataW-1:0] data);
      case (idx)
         REG_WORD_A:  cfg_words[0] = data;
         REG_WORD_B:  cfg_words[1] = data;
         REG_WORD_C:  cfg_words[2] = data;
         REG_WORD_D:  cfg_words[3] = data;
         REG_LENGTHS: cfg_lens = data[15:0];
         REG_FOLD:    cfg_fold = data[0];
         default:     ;
      endcase
   endfunction

   // ---------------------------------------------------------------- result checking

   function automatic void check_field(input string name, input int unsigned exp,
                                       input int unsigned act);
      if (exp != act) begin
         fail_count++;
         if (fail_count <= MAX_PRINTS) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
         end
      end
   endfunction

   always @(posedge clock) begin : beat_check
      token_beat_type seen;
      token_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_item_kind, rsp_data_byte, rsp_text_done, rsp_run_last};
         beats_checked++;
         if (pending_beats.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_PRINTS) begin
               $display("%0t: unexpected beat, expected none, actual %0h", $time, seen);
            end
         end else begin
            want = pending_beats.pop_front();
            check_field("item_kind", want.kind, seen.kind);
            check_field("data_byte", want.data_byte, seen.data_byte);
            check_field("text_done", want.text_done, seen.text_done);
            check_field("run_last", want.run_last, seen.run_last);
         end
      end
   end

   // Receiver backpressure: a new random mode is drawn whenever the current run ends
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = rdy_mode_type'($urandom_range(0, 3));
         ready_left = $urandom_range(16, 80);
         ready_mask = 8'($urandom_range(1, 255));
      end
      ready_left--;
      ready_mask = {ready_mask[6:0], ready_mask[7]};
      case (ready_mode)
         RDY_OPEN:  rsp_ready = 1'b1;
         RDY_COIN:  rsp_ready = ($urandom_range(0, 3) != 0);
         RDY_MASK:  rsp_ready = ready_mask[0];
         default:   rsp_ready = (ready_left % 12 < 3);
      endcase
   end

   // ---------------------------------------------------------------- drivers

   // Stop sending and wait until every expected beat has come out
   task automatic wait_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_beats.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      wait_quiet();
      csr_index = idx;
      csr_data  = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_config(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Sender works in bursts with idle gaps between them
   task automatic send_text_byte(input logic [7:0] b, input logic last,
                                 input logic pinned, input token_beat_type want);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_text_byte = b;
      req_text_last = last;
      req_valid     = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_byte(b, last, pinned, want);
      sent_bytes++;
      if (last) begin
         texts_done++;
      end
   endtask

   // ---------------------------------------------------------------- random stimulus

   function automatic logic [7:0] pick_byte();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c = 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
         4, 5, 6:    c = SEP_BYTES[$urandom_range(0, 5)];
         default:    c = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   // New delimiter setup; every fourth one is all full-length 00/FF words
   task automatic random_config(input int unsigned phase);
      logic [CsrDataW-1:0] word;
      logic [CsrDataW-1:0] lens_data;
      logic [3:0]          len;
      logic                extreme;
      extreme   = (phase % 4 == 3);
      lens_data = {$urandom, $urandom};
      for (int d = 0; d < SLOT_COUNT; d++) begin
         case ($urandom_range(0, 9))
            0:       len = 4'd0;
            1:       len = 4'($urandom_range(9, 15));
            2:       len = 4'($urandom_range(5, 8));
            default: len = 4'($urandom_range(1, 4));
         endcase
         for (int k = 0; k < 8; k++) begin
            word[8*k +: 8] = pick_byte();
         end
         if (extreme) begin
            len  = 4'd8;
            word = (d % 2 == 1) ? {CsrDataW{1'b1}} : {CsrDataW{1'b0}};
         end
         lens_data[4*d +: 4] = len;
         csr_write(WORD_REGS[d], word);
      end
      csr_write(REG_LENGTHS, lens_data);
      csr_write(REG_FOLD, {$urandom, $urandom});
   endtask

   // Text built mostly from delimiter copies (some cut short or case-flipped) and filler
   task automatic random_text();
      logic [7:0]  txt [$];
      logic [7:0]  c;
      int unsigned target;
      int unsigned slot;
      int unsigned span;
      int unsigned cut;
      logic        noise;
      noise  = ($urandom_range(0, 9) == 0);
      target = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      while (txt.size() < target) begin
         if (!noise && $urandom_range(0, 1) == 1) begin
            slot = $urandom_range(0, SLOT_COUNT - 1);
            span = 32'(cfg_lens[4*slot +: 4]);
            if (span == 0 || span > WIN_DEPTH) begin
               span = $urandom_range(1, 3);
            end
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span) : span;
            for (int k = 0; k < cut; k++) begin
               c = cfg_words[slot][8*k +: 8];
               if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7a && $urandom_range(0, 3) == 0) begin
                  c = c ^ 8'h20;
               end
               txt = {txt, c};
            end
         end else begin
            txt = {txt, pick_byte()};
         end
      end
      foreach (txt[i]) begin
         // now and then hold the sender mid-text until the block has caught up
         if (i > 0 && (drain_pauses == 0 || $urandom_range(0, 49) == 0)) begin
            wait_quiet();
            drain_pauses++;
         end
         send_text_byte(txt[i], i == txt.size() - 1, 1'b0, END_OF_TEXT);
      end
   endtask

   // ---------------------------------------------------------------- directed table

   function automatic plan_row_type byte_row(input logic [7:0] b, input logic last);
      plan_row_type r;
      r.op        = ROW_BYTE;
      r.idx       = REG_WORD_A;
      r.data      = '0;
      r.text_byte = b;
      r.last      = last;
      r.pinned    = 1'b0;
      r.want      = END_OF_TEXT;
      return r;
   endfunction

   function automatic plan_row_type pinned_row(input logic [7:0] b, input logic last,
                                               input token_beat_type want);
      plan_row_type r;
      r        = byte_row(b, last);
      r.pinned = 1'b1;
      r.want   = want;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [CsrIdxW-1:0] idx,
                                            input logic [CsrDataW-1:0] data);
      plan_row_type r;
      r      = byte_row(8'h00, 1'b0);
      r.op   = ROW_CSR;
      r.idx  = idx;
      r.data = data;
      return r;
   endfunction

   // ---------------------------------------------------------------- main sequence

   initial begin
      plan_row_type plan [$];
      int unsigned  phase;
      int unsigned  random_start;

      // out of reset nothing is live: each text is a single token
      plan = {plan, pinned_row(8'h00, 1'b1, END_OF_TEXT)};
      plan = {plan, byte_row(8'hff, 1'b0)};
      plan = {plan, pinned_row(8'ha5, 1'b1, END_OF_TEXT)};
      // comma, "ab" and "AB" tied at two, eight zero bytes; junk above the comma, "ab", length and fold fields
      plan = {plan, csr_row(REG_WORD_A, 64'hffff_ffff_ffff_ff2c)};
      plan = {plan, csr_row(REG_WORD_B, 64'hffff_ffff_ffff_6261)};
      plan = {plan, csr_row(REG_WORD_C, 64'h0000_0000_0000_4241)};
      plan = {plan, csr_row(REG_WORD_D, 64'h0000_0000_0000_0000)};
      plan = {plan, csr_row(REG_LENGTHS, 64'hffff_ffff_ffff_8221)};
      plan = {plan, csr_row(REG_FOLD, 64'hffff_ffff_ffff_fffe)};
      // folding off: mixed case misses both two-byte delimiters
      plan = {plan, byte_row("a", 1'b0)};
      plan = {plan, byte_row("B", 1'b0)};
      plan = {plan, byte_row(",", 1'b0)};
      plan = {plan, byte_row("x", 1'b1)};
      // folding switched on while "Ab" sits in the window
      plan = {plan, byte_row("A", 1'b0)};
      plan = {plan, byte_row("b", 1'b0)};
      plan = {plan, csr_row(REG_FOLD, 64'h0000_0000_0000_0001)};
      plan = {plan, byte_row(",", 1'b1)};
      // lengths nine and up count as unused, only the comma is left
      plan = {plan, csr_row(REG_LENGTHS, 64'h0000_0000_0000_f9a1)};
      plan = {plan, byte_row("a", 1'b0)};
      plan = {plan, byte_row(",", 1'b1)};
      // writes past the register map are dropped
      plan = {plan, csr_row(REG_SPARE_LO, {CsrDataW{1'b1}})};
      plan = {plan, csr_row(REG_SPARE_HI, {CsrDataW{1'b1}})};
      plan = {plan, pinned_row(",", 1'b1, END_OF_TEXT)};
      // full window of zeros matches the eight-byte delimiter
      plan = {plan, csr_row(REG_LENGTHS, 64'h0000_0000_0000_8000)};
      for (int i = 0; i < 8; i++) begin
         plan = {plan, byte_row(8'h00, 1'b0)};
      end
      plan = {plan, pinned_row(8'h00, 1'b1, END_OF_TEXT)};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].op == ROW_CSR) begin
            csr_write(plan[i].idx, plan[i].data);
         end else begin
            send_text_byte(plan[i].text_byte, plan[i].last, plan[i].pinned, plan[i].want);
         end
      end

      // random phases: new setup between texts, several texts per setup
      random_start = sent_bytes;
      phase        = 0;
      while (sent_bytes - random_start < RANDOM_BYTES) begin
         random_config(phase);
         repeat ($urandom_range(4, 10)) random_text();
         phase++;
      end

      wait_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d texts (%0d bytes) over %0d delimiter setups, %0d beats checked.",
               texts_done, sent_bytes, phase, beats_checked);
      $display("Register writes: %0d, mid-text drain pauses: %0d.", csr_writes, drain_pauses);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("Timeout with %0d beats still expected.", pending_beats.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
